FILE: hdl/twlc_pkg.sv
// Package for the two-way LRU write-back cache: default geometry, command and
// state codes, and the structs passed between the top level and the tag directory.
// No dependencies.
package twlc_pkg;

   localparam int SET_BITS_DEF    = 2;
   localparam int OFFSET_BITS_DEF = 2;
   localparam int TAG_BITS_DEF    = 3;
   localparam int DATA_BITS_DEF   = 8;

   // Fixed widths of transaction fields
   localparam int CMD_W   = 2;
   localparam int BLOCK_W = 5;
   localparam int FRAME_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ    = 2'd0,
      CMD_WRITE   = 2'd1,
      CMD_PRELOAD = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_WB,
      ST_FILL,
      ST_ACCESS,
      ST_RESP
   } state_type;

   // Lookup answer for the set under access
   typedef struct packed {
      logic hit;
      logic way;           // hit way, or victim way on a miss
      logic victim_dirty;  // miss and the victim must be written back
   } lookup_type;

   // Directory update for the set under access
   typedef struct packed {
      logic touch;         // mark way as most recently used
      logic fill;          // install tag, set valid, clear dirty
      logic mark_dirty;
      logic way;
   } dir_op_type;

endpackage

FILE: hdl/twlc_if.sv
// Channel interfaces of the two-way LRU write-back cache: request and response.
// Depends on twlc_pkg for the default geometry and the fixed field widths.
interface twlc_req_if #(
   parameter int ADDR_W = twlc_pkg::TAG_BITS_DEF + twlc_pkg::SET_BITS_DEF +
                          twlc_pkg::OFFSET_BITS_DEF,
   parameter int DATA_W = twlc_pkg::DATA_BITS_DEF
) ();
   logic                       valid;
   logic                       ready;
   logic [twlc_pkg::CMD_W-1:0] command;
   logic [ADDR_W-1:0]          address;
   logic [DATA_W-1:0]          write_data;

   modport source (output valid, command, address, write_data, input ready);
   modport sink   (input valid, command, address, write_data, output ready);
endinterface

interface twlc_rsp_if #(
   parameter int DATA_W = twlc_pkg::DATA_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic [DATA_W-1:0]            read_data;
   logic                         hit;
   logic [twlc_pkg::BLOCK_W-1:0] block_number;
   logic [twlc_pkg::FRAME_W-1:0] cache_frame;
   logic                         wrote_back;

   modport source (output valid, read_data, hit, block_number, cache_frame, wrote_back,
                   input ready);
   modport sink   (input valid, read_data, hit, block_number, cache_frame, wrote_back,
                   output ready);
endinterface

FILE: hdl/two_way_lru_writeback_cache.sv
// Two-way set-associative write-back cache with LRU replacement and its own
// main memory. Depends on twlc_pkg, twlc_if (channels) and twlc_tag_dir.
//
// A request transaction is a read, a write through the cache, or a direct
// preload of one main-memory byte; each gives exactly one response transaction.
// Main memory and cache line data live in two synchronous memories with a
// registered read; tags, valid, dirty and LRU bits live in the tag directory.
// After reset the block sweeps all 2**(TAG_BITS+SET_BITS+OFFSET_BITS) bytes of
// main memory (128 by default) to zero, one byte per cycle, with req_ch.ready
// low. After that, an item occupies the block from acceptance to handing its
// result to the output register: a hit runs lookup and access; a miss also
// fills the line from main memory, after writing back a dirty victim; preload
// and the unused command go from lookup to the response directly. The line
// moves one byte per cycle through the single write port of each memory, which
// sets the miss cost. The response register holds a finished result while the
// next request is already accepted and worked on. A preload does not touch the
// cache, so a cached copy of that byte stays stale until it is replaced. The
// unused command changes nothing and returns an all-zero response.
module two_way_lru_writeback_cache #(
   parameter int SET_BITS    = twlc_pkg::SET_BITS_DEF,
   parameter int OFFSET_BITS = twlc_pkg::OFFSET_BITS_DEF,
   parameter int TAG_BITS    = twlc_pkg::TAG_BITS_DEF,
   parameter int DATA_BITS   = twlc_pkg::DATA_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   twlc_req_if.sink    req_ch,
   twlc_rsp_if.source  rsp_ch
);
   import twlc_pkg::*;

   localparam int ADDR_BITS = TAG_BITS + SET_BITS + OFFSET_BITS;
   localparam int MEM_SIZE  = 1 << ADDR_BITS;
   localparam int LM_AW     = SET_BITS + 1 + OFFSET_BITS;
   localparam int LM_DEPTH  = 1 << LM_AW;
   localparam int BLK_BITS  = TAG_BITS + SET_BITS;

   // ---------------------------------------------------------------------
   // Control and transaction registers
   // ---------------------------------------------------------------------
   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [ADDR_BITS-1:0]   addr_ff, addr_in;
   logic [DATA_BITS-1:0]   wdata_ff, wdata_in;
   logic                   way_ff, way_in;
   logic                   hit_ff, hit_in;
   logic                   wb_ff, wb_in;
   logic [TAG_BITS-1:0]    vtag_ff, vtag_in;
   logic [OFFSET_BITS-1:0] k_ff, k_in;
   logic [DATA_BITS-1:0]   fill_byte_ff, fill_byte_in;
   logic                   use_fill_ff, use_fill_in;
   logic [ADDR_BITS-1:0]   clr_ff, clr_in;

   // Finished result waiting for the response register
   logic [DATA_BITS-1:0]   res_data_ff, res_data_in;
   logic                   res_hit_ff, res_hit_in;
   logic [BLOCK_W-1:0]     res_block_ff, res_block_in;
   logic [FRAME_W-1:0]     res_frame_ff, res_frame_in;
   logic                   res_wb_ff, res_wb_in;

   // Response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]   rsp_data_ff, rsp_data_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [BLOCK_W-1:0]     rsp_block_ff, rsp_block_in;
   logic [FRAME_W-1:0]     rsp_frame_ff, rsp_frame_in;
   logic                   rsp_wb_ff, rsp_wb_in;

   // ---------------------------------------------------------------------
   // Address fields of the transaction in flight
   // ---------------------------------------------------------------------
   logic [OFFSET_BITS-1:0] off;
   logic [SET_BITS-1:0]    set_idx;
   logic [TAG_BITS-1:0]    tag;
   logic [BLK_BITS-1:0]    blk;
   logic [OFFSET_BITS-1:0] k_next;

   assign off     = addr_ff[OFFSET_BITS-1:0];
   assign set_idx = addr_ff[OFFSET_BITS +: SET_BITS];
   assign tag     = addr_ff[ADDR_BITS-1 -: TAG_BITS];
   assign blk     = addr_ff[ADDR_BITS-1:OFFSET_BITS];
   assign k_next  = k_ff + 1'b1;

   // ---------------------------------------------------------------------
   // Tag directory
   // ---------------------------------------------------------------------
   dir_op_type           dir_op;
   lookup_type           lookup;
   logic [TAG_BITS-1:0]  victim_tag;

   twlc_tag_dir #(
      .SET_BITS (SET_BITS),
      .TAG_BITS (TAG_BITS)
   ) u_tag_dir (
      .clock      (clock),
      .reset      (reset),
      .set_idx    (set_idx),
      .tag        (tag),
      .op         (dir_op),
      .lookup     (lookup),
      .victim_tag (victim_tag)
   );

   // ---------------------------------------------------------------------
   // Main memory: one write port, one registered read port
   // ---------------------------------------------------------------------
   logic [DATA_BITS-1:0] main_mem [MEM_SIZE];
   logic                 mm_we;
   logic [ADDR_BITS-1:0] mm_waddr, mm_raddr;
   logic [DATA_BITS-1:0] mm_wdata, mm_rdata_ff;

   always_ff @(posedge clock) begin
      if (mm_we) begin
         main_mem[mm_waddr] <= mm_wdata;
      end
      mm_rdata_ff <= main_mem[mm_raddr];
   end

   // ---------------------------------------------------------------------
   // Line data memory: address is {set, way, offset}
   // ---------------------------------------------------------------------
   logic [DATA_BITS-1:0] line_mem [LM_DEPTH];
   logic                 lm_we;
   logic [LM_AW-1:0]     lm_waddr, lm_raddr;
   logic [DATA_BITS-1:0] lm_wdata, lm_rdata_ff;

   always_ff @(posedge clock) begin
      if (lm_we) begin
         line_mem[lm_waddr] <= lm_wdata;
      end
      lm_rdata_ff <= line_mem[lm_raddr];
   end

   // Byte at the address before this access: from the fill on a miss,
   // from the line memory on a hit
   logic [DATA_BITS-1:0] old_byte;
   logic                 rsp_free;

   assign old_byte = use_fill_ff ? fill_byte_ff : lm_rdata_ff;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (cmd_ff inside {CMD_PRELOAD, CMD_NONE}) begin
               state_in = ST_RESP;
            end else if (lookup.hit) begin
               state_in = ST_ACCESS;
            end else if (lookup.victim_dirty) begin
               state_in = ST_WB;
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_WB: begin
            if (k_ff == '1) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (k_ff == '1) begin
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath control
   // ---------------------------------------------------------------------
   always_comb begin
      // hold by default
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      wdata_in     = wdata_ff;
      way_in       = way_ff;
      hit_in       = hit_ff;
      wb_in        = wb_ff;
      vtag_in      = vtag_ff;
      k_in         = k_ff;
      fill_byte_in = fill_byte_ff;
      use_fill_in  = use_fill_ff;
      clr_in       = clr_ff;
      res_data_in  = res_data_ff;
      res_hit_in   = res_hit_ff;
      res_block_in = res_block_ff;
      res_frame_in = res_frame_ff;
      res_wb_in    = res_wb_ff;

      // drop the response once taken
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_block_in = rsp_block_ff;
      rsp_frame_in = rsp_frame_ff;
      rsp_wb_in    = rsp_wb_ff;

      dir_op   = '0;
      mm_we    = 1'b0;
      mm_waddr = addr_ff;
      mm_wdata = wdata_ff;
      mm_raddr = {tag, set_idx, {OFFSET_BITS{1'b0}}};
      lm_we    = 1'b0;
      lm_waddr = {set_idx, way_ff, off};
      lm_wdata = wdata_ff;
      lm_raddr = {set_idx, way_ff, off};

      case (state_ff)
         ST_CLEAR: begin
            // zero main memory, one byte per cycle
            mm_we    = 1'b1;
            mm_waddr = clr_ff;
            mm_wdata = '0;
            clr_in   = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               cmd_in   = cmd_type'(req_ch.command);
               addr_in  = req_ch.address;
               wdata_in = req_ch.write_data;
            end
         end
         ST_LOOKUP: begin
            case (cmd_ff)
               CMD_PRELOAD: begin
                  mm_we        = 1'b1;
                  res_data_in  = wdata_ff;
                  res_hit_in   = 1'b0;
                  res_block_in = BLOCK_W'(blk);
                  res_frame_in = '0;
                  res_wb_in    = 1'b0;
               end
               CMD_READ, CMD_WRITE: begin
                  dir_op.touch = 1'b1;
                  dir_op.fill  = !lookup.hit;
                  dir_op.way   = lookup.way;
                  way_in       = lookup.way;
                  hit_in       = lookup.hit;
                  wb_in        = lookup.victim_dirty;
                  vtag_in      = victim_tag;
                  use_fill_in  = !lookup.hit;
                  k_in         = '0;
                  // hit: fetch the byte; dirty miss: fetch the victim's first byte
                  if (lookup.hit) begin
                     lm_raddr = {set_idx, lookup.way, off};
                  end else begin
                     lm_raddr = {set_idx, lookup.way, {OFFSET_BITS{1'b0}}};
                  end
                  // clean miss: fetch the block's first byte
                  mm_raddr = {tag, set_idx, {OFFSET_BITS{1'b0}}};
               end
               default: begin
                  res_data_in  = '0;
                  res_hit_in   = 1'b0;
                  res_block_in = '0;
                  res_frame_in = '0;
                  res_wb_in    = 1'b0;
               end
            endcase
         end
         ST_WB: begin
            // write victim byte k back, fetch byte k+1
            mm_we    = 1'b1;
            mm_waddr = {vtag_ff, set_idx, k_ff};
            mm_wdata = lm_rdata_ff;
            lm_raddr = {set_idx, way_ff, k_next};
            mm_raddr = {tag, set_idx, {OFFSET_BITS{1'b0}}};
            k_in     = k_next;
         end
         ST_FILL: begin
            // install fetched byte k, fetch byte k+1
            lm_we    = 1'b1;
            lm_waddr = {set_idx, way_ff, k_ff};
            lm_wdata = mm_rdata_ff;
            mm_raddr = {tag, set_idx, k_next};
            if (k_ff == off) begin
               fill_byte_in = mm_rdata_ff;
            end
            k_in = k_next;
         end
         ST_ACCESS: begin
            // a write marks the line dirty only when the byte changes
            if (cmd_ff == CMD_WRITE && old_byte != wdata_ff) begin
               lm_we             = 1'b1;
               dir_op.mark_dirty = 1'b1;
               dir_op.way        = way_ff;
            end
            res_data_in  = (cmd_ff == CMD_WRITE) ? wdata_ff : old_byte;
            res_hit_in   = hit_ff;
            res_block_in = BLOCK_W'(blk);
            res_frame_in = FRAME_W'({set_idx, way_ff});
            res_wb_in    = wb_ff;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_hit_in   = res_hit_ff;
               rsp_block_in = res_block_ff;
               rsp_frame_in = res_frame_ff;
               rsp_wb_in    = res_wb_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.read_data    = rsp_data_ff;
   assign rsp_ch.hit          = rsp_hit_ff;
   assign rsp_ch.block_number = rsp_block_ff;
   assign rsp_ch.cache_frame  = rsp_frame_ff;
   assign rsp_ch.wrote_back   = rsp_wb_ff;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      addr_ff      <= addr_in;
      wdata_ff     <= wdata_in;
      way_ff       <= way_in;
      hit_ff       <= hit_in;
      wb_ff        <= wb_in;
      vtag_ff      <= vtag_in;
      k_ff         <= k_in;
      fill_byte_ff <= fill_byte_in;
      use_fill_ff  <= use_fill_in;
      res_data_ff  <= res_data_in;
      res_hit_ff   <= res_hit_in;
      res_block_ff <= res_block_in;
      res_frame_ff <= res_frame_in;
      res_wb_ff    <= res_wb_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_block_ff <= rsp_block_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_wb_ff    <= rsp_wb_in;
   end

endmodule

FILE: hdl/twlc_tag_dir.sv
// Tag directory of the two-way cache: tags, valid, dirty and LRU bits per set.
// Depends on twlc_pkg.
module twlc_tag_dir #(
   parameter int SET_BITS = twlc_pkg::SET_BITS_DEF,
   parameter int TAG_BITS = twlc_pkg::TAG_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [SET_BITS-1:0]  set_idx,
   input  logic [TAG_BITS-1:0]  tag,
   input  twlc_pkg::dir_op_type op,
   output twlc_pkg::lookup_type lookup,
   output logic [TAG_BITS-1:0]  victim_tag
);
   import twlc_pkg::*;

   localparam int NUM_SETS  = 1 << SET_BITS;
   localparam int NUM_LINES = 2 * NUM_SETS;

   // One row per set holds both ways' tags: {way1, way0}
   logic [2*TAG_BITS-1:0] tag_row [NUM_SETS];

   logic [NUM_LINES-1:0] valid_ff, valid_in;
   logic [NUM_LINES-1:0] dirty_ff, dirty_in;
   logic [NUM_SETS-1:0]  mru0_ff, mru0_in;   // way 0 was used last in this set

   logic [2*TAG_BITS-1:0] row;
   logic [TAG_BITS-1:0]   tag0, tag1;
   logic [SET_BITS:0]     f0, f1, fv, fu;
   logic                  hit0, hit1, vway;

   always_comb begin
      row  = tag_row[set_idx];
      tag0 = row[TAG_BITS-1:0];
      tag1 = row[2*TAG_BITS-1:TAG_BITS];
      f0   = {set_idx, 1'b0};
      f1   = {set_idx, 1'b1};
      hit0 = valid_ff[f0] && (tag0 == tag);
      hit1 = valid_ff[f1] && (tag1 == tag);
      // Victim is way 0 unless way 0 was used last
      vway = mru0_ff[set_idx];
      fv   = {set_idx, vway};
      fu   = {set_idx, op.way};

      lookup.hit          = hit0 | hit1;
      lookup.way          = hit0 ? 1'b0 : (hit1 ? 1'b1 : vway);
      lookup.victim_dirty = !(hit0 | hit1) && valid_ff[fv] && dirty_ff[fv];
      victim_tag          = vway ? tag1 : tag0;
   end

   always_comb begin
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      mru0_in  = mru0_ff;
      if (op.touch) begin
         mru0_in[set_idx] = ~op.way;
      end
      if (op.fill) begin
         valid_in[fu] = 1'b1;
         dirty_in[fu] = 1'b0;
      end
      if (op.mark_dirty) begin
         dirty_in[fu] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (op.fill) begin
         if (op.way) begin
            tag_row[set_idx] <= {tag, tag0};
         end else begin
            tag_row[set_idx] <= {tag1, tag};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         mru0_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         mru0_ff  <= mru0_in;
      end
   end

endmodule
